// ----- src/mm2h_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm2h_pkg
// Shared types and constants for the streaming 32-bit murmur2 hash core.
// ----------------------------------------------------------------------------
package mm2h_pkg;

  localparam logic [31:0] MIX_MUL    = 32'h5bd1_e995;
  localparam logic [31:0] SEED_RESET = 32'h9747_b28c;
  localparam int unsigned MIX_SHIFT  = 24;
  localparam int unsigned FIN_SHIFT1 = 13;
  localparam int unsigned FIN_SHIFT2 = 15;

  // operations of the shared multiply unit
  typedef enum logic [2:0] {
    OP_KMIX1 = 3'd0,  // k * m, then xor with itself shifted right 24
    OP_KMIX2 = 3'd1,  // k * m
    OP_HFOLD = 3'd2,  // h * m, then xor k
    OP_TAIL  = 3'd3,  // (h ^ tail) * m
    OP_FIN   = 3'd4   // (h ^ h >> 13) * m
  } mix_op_t;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE = 7'b000_0001,
    ST_MK1  = 7'b000_0010,
    ST_MK2  = 7'b000_0100,
    ST_MH   = 7'b000_1000,
    ST_TAIL = 7'b001_0000,
    ST_FIN  = 7'b010_0000,
    ST_OUT  = 7'b100_0000
  } seq_state_t;

  // sign-extend one byte to 32 bits
  function automatic logic [31:0] sext8(input logic [7:0] b);
    sext8 = {{24{b[7]}}, b};
  endfunction

  // tail bytes folded into the hash; held bytes sit low byte first
  function automatic logic [31:0] tail_xor(input logic [23:0] pw, input logic [1:0] phase);
    logic [31:0] t;
    t = '0;
    case (phase)
      2'd1: t = sext8(pw[7:0]);
      2'd2: t = (sext8(pw[7:0]) << 8) ^ sext8(pw[15:8]);
      2'd3: t = (sext8(pw[7:0]) << 16) ^ (sext8(pw[15:8]) << 8) ^ sext8(pw[23:16]);
      default: t = '0;
    endcase
    tail_xor = t;
  endfunction

endpackage
`default_nettype wire

// ----- src/mm2h_mix_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm2h_mix_unit
// Shared 32x32 low-half multiplier by the mix constant with the small
// pre and post xor-shift steps that surround each use of it.
// ----------------------------------------------------------------------------
module mm2h_mix_unit
  import mm2h_pkg::*;
(
  input  wire mix_op_t     op,
  input  wire logic [31:0] k_in,
  input  wire logic [31:0] h_in,
  input  wire logic [31:0] tail_in,
  output logic [31:0]      res
);

  logic [31:0] opnd;
  logic [31:0] prod;

  // operand select
  always_comb begin
    case (op)
      OP_KMIX1, OP_KMIX2: opnd = k_in;
      OP_HFOLD:           opnd = h_in;
      OP_TAIL:            opnd = h_in ^ tail_in;
      OP_FIN:             opnd = h_in ^ (h_in >> FIN_SHIFT1);
      default:            opnd = h_in;
    endcase
  end

  // the one multiplier, low 32 bits kept
  assign prod = opnd * MIX_MUL;

  // post step
  always_comb begin
    case (op)
      OP_KMIX1: res = prod ^ (prod >> MIX_SHIFT);
      OP_HFOLD: res = prod ^ k_in;
      default:  res = prod;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/murmur2_hash32_stream_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// murmur2_hash32_stream_core
// Streaming 32-bit murmur2 hash over a byte string, one byte per item.
// ----------------------------------------------------------------------------
// A string arrives one byte per item; the first item carries the total length
// and tuser set, the last item has tlast set, and a zero-length string is one
// item with both set and length 0. A byte that does not complete a four-byte
// word is only stored and, unless it is last, the core stays ready for the
// next byte. The byte that completes a word holds off input while it passes
// three times through the one shared 32x32 multiplier (MK1, MK2, MH). On the
// last item the finish runs TAIL when one to three tail bytes are held, then
// FIN, then OUT loads the output register, where the hash waits while the
// next string is already taken in; that load stalls only while an earlier
// hash is still held. Tail bytes are folded in as sign-extended bytes. The
// seed register may be written while the core is idle; it resets to 0x9747b28c.
// ----------------------------------------------------------------------------
module murmur2_hash32_stream_core
  import mm2h_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // seed write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] byte_value, [23:8] total_length
  input  wire logic        in_tuser,   // [0] first_byte
  input  wire logic        in_tlast,   // last_byte
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [31:0] hash_value
);

  seq_state_t  state_r, state_nxt;
  logic [31:0] seed_r;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] k_r, k_nxt;
  logic [23:0] pw_r, pw_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;

  mix_op_t     mix_op;
  logic [31:0] mix_res;

  logic        in_acc;
  logic [7:0]  in_byte;
  logic [15:0] in_len;
  logic [31:0] hash0;
  logic [23:0] pw0;
  logic [1:0]  phase0;
  logic        skip_byte;
  logic        out_free;

  assign in_byte   = in_tdata[7:0];
  assign in_len    = in_tdata[23:8];
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = ~out_valid_r | out_tready;

  // string start restarts the state
  assign hash0     = in_tuser ? (seed_r ^ {16'd0, in_len}) : hash_r;
  assign pw0       = in_tuser ? 24'd0 : pw_r;
  assign phase0    = in_tuser ? 2'd0 : phase_r;
  assign skip_byte = in_tuser & in_tlast & (in_len == 16'd0);

  mm2h_mix_unit u_mix (
    .op      (mix_op),
    .k_in    (k_r),
    .h_in    (hash_r),
    .tail_in (tail_xor(pw_r, phase_r)),
    .res     (mix_res)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    k_nxt         = k_r;
    pw_nxt        = pw_r;
    phase_nxt     = phase_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    mix_op        = OP_KMIX1;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          hash_nxt  = hash0;
          pw_nxt    = pw0;
          phase_nxt = phase0;
          last_nxt  = in_tlast;
          if (skip_byte) begin
            state_nxt = ST_FIN;
          end else if (phase0 == 2'd3) begin
            // word complete: start mixing it
            k_nxt     = {in_byte, pw0};
            pw_nxt    = 24'd0;
            phase_nxt = 2'd0;
            state_nxt = ST_MK1;
          end else begin
            case (phase0)
              2'd0: pw_nxt = {pw0[23:8], in_byte};
              2'd1: pw_nxt = {pw0[23:16], in_byte, pw0[7:0]};
              default: pw_nxt = {in_byte, pw0[15:0]};
            endcase
            phase_nxt = phase0 + 2'd1;
            if (in_tlast) begin
              state_nxt = ST_TAIL;
            end
          end
        end
      end
      ST_MK1: begin
        mix_op    = OP_KMIX1;
        k_nxt     = mix_res;
        state_nxt = ST_MK2;
      end
      ST_MK2: begin
        mix_op    = OP_KMIX2;
        k_nxt     = mix_res;
        state_nxt = ST_MH;
      end
      ST_MH: begin
        mix_op    = OP_HFOLD;
        hash_nxt  = mix_res;
        state_nxt = last_r ? ST_FIN : ST_IDLE;
      end
      ST_TAIL: begin
        mix_op    = OP_TAIL;
        hash_nxt  = mix_res;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        mix_op    = OP_FIN;
        hash_nxt  = mix_res;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // load the result once the output register is free
        if (out_free) begin
          out_data_nxt  = hash_r ^ (hash_r >> FIN_SHIFT2);
          out_valid_nxt = 1'b1;
          hash_nxt      = 32'd0;
          pw_nxt        = 24'd0;
          phase_nxt     = 2'd0;
          last_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= SEED_RESET;
      hash_r      <= 32'd0;
      pw_r        <= 24'd0;
      phase_r     <= 2'd0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      pw_r        <= pw_nxt;
      phase_r     <= phase_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        seed_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire
